FILE: rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants of the button debounce classifier
// Register map, reset values of the timing registers and the lane settings.
// ----------------------------------------------------------------------------
package bdpc_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STARTUP_BLANK = 3'd0,
		REG_POLL_INTERVAL = 3'd1,
		REG_DEBOUNCE      = 3'd2,
		REG_LONG_PRESS    = 3'd3,
		REG_SHORT_WINDOW  = 3'd4
	} cfg_reg_t;

	localparam logic [15:0] STARTUP_BLANK_RST = 16'd500;
	localparam logic [7:0]  POLL_INTERVAL_RST = 8'd10;
	localparam logic [7:0]  DEBOUNCE_RST      = 8'd20;
	localparam logic [15:0] LONG_PRESS_RST    = 16'd1000;
	localparam logic [15:0] SHORT_WINDOW_RST  = 16'd500;

	// Timing settings that every button lane sees.
	typedef struct packed {
		logic [7:0]  debounce_ms;
		logic [15:0] long_press_ms;
		logic [15:0] short_window_ms;
	} lane_cfg_t;

endpackage

FILE: rtl/bdpc_lane.sv
// ----------------------------------------------------------------------------
// bdpc_lane: debounce and press classification for one button
// Holds the per-button state and updates it on every evaluated poll.
// ----------------------------------------------------------------------------
module bdpc_lane #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  poll,
	input  logic [TIME_WIDTH-1:0] now,
	input  bdpc_pkg::lane_cfg_t   cfg,
	input  logic                  raw,
	output logic                  long_hit,
	output logic                  short_hit,
	output logic                  level
);

	logic                  prev_q, deb_q, held_q, lf_q, sd_q;
	logic [TIME_WIDTH-1:0] edge_q, press_q;

	logic                  acc, lhit, shit;
	logic                  deb_n, held_n, lf_a, lf_n, sd_a, sd_b, sd_n;
	logic [TIME_WIDTH-1:0] edge_n, press_n, edge_el, press_el;

	always_comb begin
		edge_n   = (raw != prev_q) ? now : edge_q;
		edge_el  = now - edge_n;
		acc      = (edge_el > TIME_WIDTH'(cfg.debounce_ms)) && (raw != deb_q);
		deb_n    = acc ? raw : deb_q;
		press_n  = (acc && !raw) ? now : press_q;
		held_n   = acc ? !raw : held_q;
		lf_a     = acc ? 1'b0 : lf_q;
		sd_a     = (acc && !raw) ? 1'b0 : sd_q;
		press_el = now - press_n;
		lhit     = held_n && !lf_a && !deb_n &&
		           (press_el > TIME_WIDTH'(cfg.long_press_ms));
		lf_n     = lf_a | lhit;
		sd_b     = sd_a | lhit;
		// A release seen on the raw line inside the window flags a short press,
		// which also catches a glitch that never became a debounced press.
		shit     = !held_n && raw && deb_n && !sd_b &&
		           (edge_el < TIME_WIDTH'(cfg.short_window_ms));
		sd_n     = sd_b | shit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b1;
			deb_q   <= 1'b1;
			held_q  <= 1'b0;
			lf_q    <= 1'b0;
			sd_q    <= 1'b0;
			edge_q  <= '0;
			press_q <= '0;
		end else if (poll) begin
			prev_q  <= raw;
			deb_q   <= deb_n;
			held_q  <= held_n;
			lf_q    <= lf_n;
			sd_q    <= sd_n;
			edge_q  <= edge_n;
			press_q <= press_n;
		end
	end

	assign long_hit  = poll && lhit;
	assign short_hit = poll && shit;
	assign level     = poll ? deb_n : deb_q;

	// A button is either held or not, so both flags can never fire together.
	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(long_hit && short_hit))
		else $error("long and short press on the same tick");

	// Once a long press fired, it stays latched until a new level is accepted.
	a_long_once: assert property (@(posedge clk) disable iff (!arst_n)
		long_hit |=> (lf_q && !lhit))
		else $error("long press not latched");

endmodule

FILE: rtl/bdpc_skid.sv
// ----------------------------------------------------------------------------
// bdpc_skid: two-entry output queue
// Lets the block take a new tick while a finished result waits downstream.
// ----------------------------------------------------------------------------
module bdpc_skid #(
	parameter int WIDTH = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full output queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output queue count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

FILE: rtl/button_debounce_press_classifier.sv
// Each result beat is registered in the output queue as its tick is accepted.
// Throughput: one tick per clock cycle unless the output queue is full; each lane
// registers its new state on a polled tick and the next tick reads it straight back.
// A two-entry output queue stalls the input only when both entries hold waiting beats.
// Reset clears the time base and the queue, puts all button state at released,
// and loads the default timing registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// button_debounce_press_classifier: debounce and long/short press detection
// Each input beat is one millisecond tick carrying the raw active-low button
// levels. One lane per button does the debounce and classification; the
// press flags of all lanes are merged into masks and queued for output.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier #(
	parameter int NUM_BUTTONS = 4,
	parameter int TIME_WIDTH  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_wr_en,
	input  logic [bdpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bdpc_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Tick input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [NUM_BUTTONS-1:0]            raw_levels,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [NUM_BUTTONS-1:0]            long_press_mask,
	output logic [NUM_BUTTONS-1:0]            short_press_mask,
	output logic [NUM_BUTTONS-1:0]            stable_levels
);

	localparam int PAYLOAD_W = 3 * NUM_BUTTONS;

	// Timing registers.
	logic [15:0] startup_q;
	logic [7:0]  poll_iv_q;
	logic [7:0]  debounce_q;
	logic [15:0] long_q;
	logic [15:0] short_q;

	// Time base and poll scheduling.
	logic [TIME_WIDTH-1:0] tick_q;
	logic [TIME_WIDTH-1:0] last_poll_q;
	logic                  blank_over_q;

	logic                  accept, blank_ok, poll;
	logic [TIME_WIDTH-1:0] since_poll;
	bdpc_pkg::lane_cfg_t   lane_cfg;

	logic [NUM_BUTTONS-1:0] long_hit, short_hit, level;
	logic                   queue_full;
	logic [PAYLOAD_W-1:0]   out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_q  <= bdpc_pkg::STARTUP_BLANK_RST;
			poll_iv_q  <= bdpc_pkg::POLL_INTERVAL_RST;
			debounce_q <= bdpc_pkg::DEBOUNCE_RST;
			long_q     <= bdpc_pkg::LONG_PRESS_RST;
			short_q    <= bdpc_pkg::SHORT_WINDOW_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bdpc_pkg::REG_STARTUP_BLANK: startup_q  <= cfg_data[15:0];
				bdpc_pkg::REG_POLL_INTERVAL: poll_iv_q  <= cfg_data[7:0];
				bdpc_pkg::REG_DEBOUNCE:      debounce_q <= cfg_data[7:0];
				bdpc_pkg::REG_LONG_PRESS:    long_q     <= cfg_data[15:0];
				bdpc_pkg::REG_SHORT_WINDOW:  short_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;

	// The tick count itself is the time since reset, so blanking ends once it
	// reaches the blanking length; after that the flag keeps it over, even
	// when the count wraps.
	assign blank_ok   = blank_over_q || (tick_q >= TIME_WIDTH'(startup_q));
	assign since_poll = tick_q - last_poll_q;
	assign poll       = accept && blank_ok && (since_poll >= TIME_WIDTH'(poll_iv_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			last_poll_q  <= '0;
			blank_over_q <= 1'b0;
		end else if (accept) begin
			tick_q <= tick_q + TIME_WIDTH'(1);
			if (blank_ok) begin
				blank_over_q <= 1'b1;
			end
			if (poll) begin
				last_poll_q <= tick_q;
			end
		end
	end

	assign lane_cfg.debounce_ms     = debounce_q;
	assign lane_cfg.long_press_ms   = long_q;
	assign lane_cfg.short_window_ms = short_q;

	// One lane per button, all sharing the same poll strobe and time stamp.
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		bdpc_lane #(
			.TIME_WIDTH(TIME_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.poll     (poll),
			.now      (tick_q),
			.cfg      (lane_cfg),
			.raw      (raw_levels[i]),
			.long_hit (long_hit[i]),
			.short_hit(short_hit[i]),
			.level    (level[i])
		);
	end

	// Merge stage: the lane flags are gathered into one result beat, which is
	// queued so that one waiting result does not hold up the next tick; two do.
	bdpc_skid #(
		.WIDTH(PAYLOAD_W)
	) u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data({long_hit, short_hit, level}),
		.full     (queue_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	assign long_press_mask  = out_data[3*NUM_BUTTONS-1:2*NUM_BUTTONS];
	assign short_press_mask = out_data[2*NUM_BUTTONS-1:NUM_BUTTONS];
	assign stable_levels    = out_data[NUM_BUTTONS-1:0];

endmodule
